// ===== hw/rtl/lssp_pkg.sv =====
// shared types and constants of the link-state shortest path engine
// no dependencies
`default_nettype none
package lssp_pkg;
    localparam int ID_W        = 4;
    localparam int PATH_W      = 20;
    localparam int LINK_COST_W = 16;
    localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

    typedef enum logic {
        FUNC_LINK  = 1'b0,
        FUNC_ROUTE = 1'b1
    } func_t;

    typedef struct packed {
        logic              upd;
        logic [PATH_W-1:0] cost;
    } relax_t;
endpackage
`default_nettype wire

// ===== hw/rtl/link_state_shortest_path_core.sv =====
// link-state route engine: link matrix ram, distance ram, dijkstra sequencer
// a link transfer makes two matrix writes (a,b then b,a); a route transfer runs, per settled node,
// one scan pass over the distance ram and one relax pass over the matrix row,
// plus one final scan pass and an emit pass with one entry per present node
// after reset a clearing pass over all NODES*NODES entries empties the link matrix, s_tready low
// depends on lssp_pkg, lssp_ram, lssp_relax
`default_nettype none
module link_state_shortest_path_core #(
    parameter int NODES     = 16,
    parameter int COST_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // node_a, node_b, link_cost, link_up
    input  wire logic        s_tuser,  // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // dest_node, next_hop, path_cost, predecessor, reachable
    output logic             m_tlast   // last
);
    import lssp_pkg::*;

    localparam int NB = $clog2(NODES);
    localparam int CW = NB + 1;
    localparam int MD = NODES * NODES;
    localparam int MW = $clog2(MD);
    localparam int LW = COST_BITS + 1;
    localparam int DW = PATH_W + 2 * NB;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LINK2, S_SCAN, S_RELAX, S_EMIT_RD, S_EMIT_LD
    } state_t;

    state_t             state_reg;
    logic [MW-1:0]      clr_reg;
    logic [CW-1:0]      cnt_reg;
    logic [NB-1:0]      pv_reg;
    logic               pval_reg;
    logic [NB-1:0]      lk_a_reg, lk_b_reg;
    logic [LW-1:0]      lk_word_reg;
    logic [NODES-1:0]   present_reg, reached_reg, settled_reg;
    logic [NB-1:0]      src_reg, u_reg;
    logic               found_reg;
    logic [PATH_W-1:0]  min_cost_reg;
    logic [NB-1:0]      min_hop_reg;
    logic               m_tvalid_reg, m_tlast_reg;
    logic [39:0]        m_tdata_reg;

    logic [ID_W-1:0]        in_a, in_b;
    logic [LINK_COST_W-1:0] in_cost;
    logic                   in_up, in_fire, a_ok, b_ok;
    logic [NB-1:0]          a_idx, b_idx, cnt_idx;
    logic [LW-1:0]          in_word;

    logic           mat_we, dist_we;
    logic [MW-1:0]  mat_waddr, mat_raddr;
    logic [LW-1:0]  mat_wdata, mat_rdata;
    logic [NB-1:0]  dist_waddr;
    logic [DW-1:0]  dist_wdata, dist_rdata;

    logic [PATH_W-1:0] d_cost;
    logic [NB-1:0]     d_hop, d_prior, new_hop;
    relax_t            rlx;
    logic              out_free, is_last, issuing;

    assign in_a    = s_tdata[3:0];
    assign in_b    = s_tdata[7:4];
    assign in_cost = s_tdata[23:8];
    assign in_up   = s_tdata[24];
    assign in_fire = s_tvalid && s_tready;
    assign a_ok    = int'(in_a) < NODES;
    assign b_ok    = int'(in_b) < NODES;
    assign a_idx   = NB'(in_a);
    assign b_idx   = NB'(in_b);
    assign in_word = in_up ? {1'b1, COST_BITS'(in_cost)} : '0;
    assign cnt_idx = cnt_reg[NB-1:0];

    assign d_cost  = dist_rdata[PATH_W-1:0];
    assign d_hop   = dist_rdata[PATH_W+NB-1:PATH_W];
    assign d_prior = dist_rdata[DW-1:PATH_W+NB];
    assign new_hop = (u_reg == src_reg) ? pv_reg : min_hop_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = ((present_reg >> cnt_idx) >> 1) == '0;
    assign issuing  = int'(cnt_reg) < NODES;

    assign mat_raddr  = MW'(int'(u_reg) * NODES + int'(cnt_idx));
    assign dist_waddr = (state_reg == S_RELAX) ? pv_reg : a_idx;

    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = clr_reg;
        mat_wdata = '0;
        case (state_reg)
            S_CLEAR: begin
                mat_we = 1'b1;
            end
            S_IDLE: begin
                mat_we    = in_fire && (s_tuser == FUNC_LINK) && a_ok && b_ok;
                mat_waddr = MW'(int'(a_idx) * NODES + int'(b_idx));
                mat_wdata = in_word;
            end
            S_LINK2: begin
                mat_we    = 1'b1;
                mat_waddr = MW'(int'(lk_b_reg) * NODES + int'(lk_a_reg));
                mat_wdata = lk_word_reg;
            end
            default: begin
                mat_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (state_reg == S_RELAX) begin
            dist_we    = pval_reg && rlx.upd;
            dist_wdata = {u_reg, new_hop, rlx.cost};
        end else begin
            dist_we    = in_fire && (s_tuser == FUNC_ROUTE) && a_ok;
            dist_wdata = {a_idx, a_idx, {PATH_W{1'b0}}};
        end
    end

    lssp_ram #(.WIDTH(LW), .DEPTH(MD)) u_mat (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    lssp_ram #(.WIDTH(DW), .DEPTH(NODES)) u_dist (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (cnt_idx),
        .rdata (dist_rdata)
    );

    lssp_relax #(.NB(NB), .COST_BITS(COST_BITS)) u_relax (
        .base_cost   (min_cost_reg),
        .link_valid  (mat_rdata[LW-1]),
        .link_cost   (mat_rdata[COST_BITS-1:0]),
        .u           (u_reg),
        .dst_reached (reached_reg[pv_reg]),
        .dst_settled (settled_reg[pv_reg]),
        .dst_cost    (d_cost),
        .dst_prior   (d_prior),
        .res         (rlx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            pval_reg     <= 1'b0;
            present_reg  <= '0;
            reached_reg  <= '0;
            settled_reg  <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && (state_reg != S_EMIT_LD)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == MW'(MD - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        if (s_tuser == FUNC_LINK) begin
                            if (a_ok && b_ok) begin
                                lk_a_reg    <= a_idx;
                                lk_b_reg    <= b_idx;
                                lk_word_reg <= in_word;
                                present_reg <= present_reg | (NODES'(1) << a_idx) |
                                               (NODES'(1) << b_idx);
                                state_reg   <= S_LINK2;
                            end
                        end else begin
                            src_reg     <= a_idx;
                            settled_reg <= '0;
                            cnt_reg     <= '0;
                            pval_reg    <= 1'b0;
                            found_reg   <= 1'b0;
                            if (a_ok) begin
                                reached_reg <= NODES'(1) << a_idx;
                                state_reg   <= S_SCAN;
                            end else begin
                                reached_reg <= '0;
                                state_reg   <= S_EMIT_RD;
                            end
                        end
                    end
                end
                S_LINK2: begin
                    state_reg <= S_IDLE;
                end
                S_SCAN: begin
                    pval_reg <= issuing;
                    pv_reg   <= cnt_idx;
                    if (issuing) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (pval_reg && reached_reg[pv_reg] && !settled_reg[pv_reg] &&
                        (!found_reg || (d_cost < min_cost_reg))) begin
                        found_reg    <= 1'b1;
                        u_reg        <= pv_reg;
                        min_cost_reg <= d_cost;
                        min_hop_reg  <= d_hop;
                    end
                    if (!issuing && !pval_reg) begin
                        cnt_reg <= '0;
                        if (found_reg) begin
                            settled_reg[u_reg] <= 1'b1;
                            state_reg          <= S_RELAX;
                        end else begin
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                S_RELAX: begin
                    pval_reg <= issuing;
                    pv_reg   <= cnt_idx;
                    if (issuing) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (pval_reg && rlx.upd) begin
                        reached_reg[pv_reg] <= 1'b1;
                    end
                    if (!issuing && !pval_reg) begin
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_EMIT_RD: begin
                    if (!issuing) begin
                        state_reg <= S_IDLE;
                    end else if (present_reg[cnt_idx]) begin
                        state_reg <= S_EMIT_LD;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_EMIT_LD: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= is_last;
                        if (settled_reg[cnt_idx]) begin
                            m_tdata_reg <= {7'b0, 1'b1, ID_W'(d_prior), d_cost,
                                            ID_W'(d_hop), ID_W'(cnt_idx)};
                        end else begin
                            m_tdata_reg <= {7'b0, 1'b0, {ID_W{1'b0}}, {PATH_W{1'b0}},
                                            {ID_W{1'b0}}, ID_W'(cnt_idx)};
                        end
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= is_last ? S_IDLE : S_EMIT_RD;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lssp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none
module lssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lssp_relax.sv =====
// edge relaxation: saturating candidate cost and update decision
// depends on lssp_pkg
`default_nettype none
module lssp_relax #(
    parameter int NB        = 4,
    parameter int COST_BITS = 16
) (
    input  wire logic [lssp_pkg::PATH_W-1:0] base_cost,
    input  wire logic                        link_valid,
    input  wire logic [COST_BITS-1:0]        link_cost,
    input  wire logic [NB-1:0]               u,
    input  wire logic                        dst_reached,
    input  wire logic                        dst_settled,
    input  wire logic [lssp_pkg::PATH_W-1:0] dst_cost,
    input  wire logic [NB-1:0]               dst_prior,
    output lssp_pkg::relax_t                 res
);
    import lssp_pkg::*;

    localparam int SW = ((PATH_W > COST_BITS) ? PATH_W : COST_BITS) + 1;

    logic [SW-1:0]     sum;
    logic [PATH_W-1:0] cand;

    assign sum  = SW'(base_cost) + SW'(link_cost);
    assign cand = (sum > SW'(PATH_MAX)) ? PATH_MAX : sum[PATH_W-1:0];

    always_comb begin
        res.cost = cand;
        res.upd  = link_valid && !dst_settled &&
                   (!dst_reached || (cand < dst_cost) ||
                    ((cand == dst_cost) && (u < dst_prior)));
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lssp_checker.sv =====
// port-level checks for the link-state route engine and its bind
// depends on lssp_pkg and link_state_shortest_path_core
`default_nettype none
module lssp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);
    import lssp_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_link_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_LINK) && !m_tvalid |=> !m_tvalid)
        else $error("link transfer produced a result");

    a_busy_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a table");

    a_route_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_ROUTE) |=> !s_tready)
        else $error("input ready right after a route transfer");
endmodule

bind link_state_shortest_path_core lssp_checker u_lssp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== bench/lssp_route_checker.sv =====
// watches both channels of the link-state route engine, predicts routing tables
// and compares every output transfer; depends on lssp_pkg
`default_nettype none
module lssp_route_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending_entries
);
    timeunit 1ns;
    timeprecision 1ps;
    import lssp_pkg::*;

    localparam int N = 16;

    typedef struct packed {
        logic [3:0]  dest;
        logic [3:0]  hop;
        logic [19:0] cost;
        logic [3:0]  pred;
        logic        reach;
        logic        last;
    } route_entry_t;

    logic        link_ok [N*N];
    logic [15:0] link_w  [N*N];
    logic [N-1:0] present;
    route_entry_t route_q[$];

    assign pending_entries = route_q.size();

    initial begin
        fail_count = 0;
        present = '0;
        for (int i = 0; i < N*N; i++) begin
            link_ok[i] = 1'b0;
            link_w[i] = '0;
        end
    end

    function automatic logic [19:0] sat_add(logic [19:0] a, logic [15:0] b);
        logic [20:0] s;
        s = {1'b0, a} + b;
        return s[20] ? PATH_MAX : s[19:0];
    endfunction

    task automatic build_routes(input logic [3:0] src);
        logic [19:0] path_len [N];
        logic [3:0]  hop [N];
        logic [3:0]  pred [N];
        logic [N-1:0] seen, done;
        int u, idx, cnt, lastpos;
        logic [19:0] cand;
        route_entry_t e;
        seen = '0;
        done = '0;
        for (int i = 0; i < N; i++) begin
            path_len[i] = '0; hop[i] = '0; pred[i] = '0;
        end
        seen[src] = 1'b1;
        hop[src] = src;
        pred[src] = src;
        forever begin
            u = N;
            for (int v = 0; v < N; v++)
                if (seen[v] && !done[v] && (u == N || path_len[v] < path_len[u])) u = v;
            if (u == N) break;
            done[u] = 1'b1;
            for (int v = 0; v < N; v++) begin
                idx = u*N + v;
                if (!link_ok[idx] || done[v]) continue;
                cand = sat_add(path_len[u], link_w[idx]);
                if (!seen[v] || cand < path_len[v] ||
                    (cand == path_len[v] && u < pred[v])) begin
                    seen[v] = 1'b1;
                    path_len[v] = cand;
                    pred[v] = u[3:0];
                    hop[v] = (u == src) ? v[3:0] : hop[u];
                end
            end
        end
        cnt = 0;
        for (int d = 0; d < N; d++) begin
            if (!present[d]) continue;
            e.dest = d[3:0];
            e.reach = done[d];
            e.hop = done[d] ? hop[d] : '0;
            e.cost = done[d] ? path_len[d] : '0;
            e.pred = done[d] ? pred[d] : '0;
            e.last = 1'b0;
            route_q.insert(route_q.size(), e);
            cnt++;
        end
        if (cnt > 0) begin
            lastpos = route_q.size() - 1;
            route_q[lastpos].last = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [3:0] a, b;
        route_entry_t w;
        if (aresetn && s_tvalid && s_tready) begin
            a = s_tdata[3:0];
            b = s_tdata[7:4];
            if (func_t'(s_tuser) == FUNC_ROUTE) begin
                build_routes(a);
            end else begin
                link_ok[a*N+b] = s_tdata[24];
                link_ok[b*N+a] = s_tdata[24];
                link_w[a*N+b] = s_tdata[24] ? s_tdata[23:8] : '0;
                link_w[b*N+a] = s_tdata[24] ? s_tdata[23:8] : '0;
                present[a] = 1'b1;
                present[b] = 1'b1;
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (route_q.size() == 0) begin
                report_mismatch("unexpected entry dest", m_tdata[3:0], 0);
            end else begin
                w = route_q.pop_front();
                if (m_tdata[3:0] !== w.dest) report_mismatch("dest_node", m_tdata[3:0], w.dest);
                if (m_tdata[7:4] !== w.hop) report_mismatch("next_hop", m_tdata[7:4], w.hop);
                if (m_tdata[27:8] !== w.cost)
                    report_mismatch("path_cost", m_tdata[27:8], w.cost);
                if (m_tdata[31:28] !== w.pred)
                    report_mismatch("predecessor", m_tdata[31:28], w.pred);
                if (m_tdata[32] !== w.reach) report_mismatch("reachable", m_tdata[32], w.reach);
                if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
            end
        end
    end
endmodule
`default_nettype wire

// ===== bench/tb_link_state_shortest_path_core.sv =====
// stimulus and verdict for the link-state route engine
// depends on lssp_pkg, link_state_shortest_path_core and lssp_route_checker
`default_nettype none
module tb_link_state_shortest_path_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lssp_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending_entries;
    int          idle_cycles = 0;
    int          rx_gap = 0;
    bit          hold_sink = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    link_state_shortest_path_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    lssp_route_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_entries(pending_entries)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input func_t f, input logic [3:0] a, input logic [3:0] b,
                             input logic [15:0] c, input logic up);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata <= {7'd0, up, c, b, a};
        s_tuser <= f;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_link(input logic [3:0] a, input logic [3:0] b,
                             input logic [15:0] c, input logic up);
        send_item(FUNC_LINK, a, b, c, up);
    endtask

    task automatic send_route(input logic [3:0] src);
        send_item(FUNC_ROUTE, src, 4'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (pending_entries != 0) @(negedge aclk);
    endtask

    // receiver stalls: random gaps, with one long forced hold-off
    always @(negedge aclk) begin
        if (!aresetn || hold_sink) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            rx_gap = gap_len();
            m_tready <= (rx_gap == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int kind;
        int k;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_route(4'd0);
        send_link(4'd0, 4'd1, 16'd5, 1'b1);
        send_link(4'd1, 4'd2, 16'd3, 1'b1);
        send_link(4'd0, 4'd2, 16'd8, 1'b1);
        send_link(4'd2, 4'd15, 16'hFFFF, 1'b1);
        send_link(4'd15, 4'd14, 16'hFFFF, 1'b1);
        send_link(4'd3, 4'd3, 16'd7, 1'b1);
        send_link(4'd4, 4'd5, 16'd0, 1'b1);
        send_route(4'd0);
        send_route(4'd15);
        send_route(4'd3);
        send_route(4'd9);
        send_link(4'd0, 4'd2, 16'd0, 1'b0);
        send_link(4'd5, 4'd6, 16'd1, 1'b1);
        send_link(4'd4, 4'd6, 16'd1, 1'b1);
        send_route(4'd4);
        send_route(4'd2);
        drain_wait();

        // long receiver hold-off while routes keep coming
        hold_sink <= 1'b1;
        fork
            begin
                repeat (3000) @(negedge aclk);
                hold_sink <= 1'b0;
            end
            for (int i = 0; i < 6; i++) send_route(4'($urandom));
        join
        drain_wait();

        for (int n = 0; n < 480; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                k = $urandom_range(0, 99);
                send_link(4'($urandom_range(0, k < 60 ? 7 : 15)),
                          4'($urandom_range(0, k < 60 ? 7 : 15)),
                          k < 20 ? 16'($urandom_range(0, 20)) :
                          (k < 30 ? 16'($urandom_range(65500, 65535)) : 16'($urandom)),
                          $urandom_range(0, 9) != 0);
            end else begin
                send_route(4'($urandom));
            end
            if (n == 240) drain_wait();
        end
        drain_wait();
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
